>>> hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int ENTRY_W       = 8;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_REAR  = 2'd0,
        KIND_POP_FRONT  = 2'd1,
        KIND_PUSH_FRONT = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted operation
        logic exec;     // perform the operation, update pointers and count
        logic capture;  // take popped byte from the ram read port
    } dq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_ok;   // operation in hand is a pop that will succeed
    } dq_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: accepts one beat, runs it through execute, optional ram read,
// and a one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire dq_pkg::dq_stat_t   stat,
    output dq_pkg::dq_cmd_t         cmd,
    output logic                    busy,
    output logic                    done
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.pop_ok ? dq_pkg::ST_READ : dq_pkg::ST_RESP;
            end
            dq_pkg::ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = dq_pkg::ST_RESP;
            end
            dq_pkg::ST_RESP:
            begin
                done       = 1'b1;
                state_next = dq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Head and tail pointers, entry count, entry ram and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dq_pkg::dq_cmd_t               cmd,
    input  wire logic [dq_pkg::KIND_W-1:0]     kind,
    input  wire logic [dq_pkg::ENTRY_W-1:0]    push_byte,
    output dq_pkg::dq_stat_t                   stat,
    output logic      [dq_pkg::ENTRY_W-1:0]    pop_byte,
    output logic      [dq_pkg::STATUS_W-1:0]   status,
    output logic      [dq_pkg::FILL_W-1:0]     fill_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dq_pkg::kind_t                 kind_reg;
    logic [dq_pkg::ENTRY_W-1:0]    byte_reg;
    logic [PTR_W-1:0]              head_reg;
    logic [PTR_W-1:0]              head_next;
    logic [PTR_W-1:0]              tail_reg;
    logic [PTR_W-1:0]              tail_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [dq_pkg::ENTRY_W-1:0]    pop_byte_reg;
    dq_pkg::status_t               status_reg;
    dq_pkg::status_t               status_next;
    logic [dq_pkg::FILL_W-1:0]     fill_reg;

    logic                          is_push;
    logic                          full;
    logic                          empty;
    logic                          push_ok;
    logic                          pop_ok;
    logic [PTR_W-1:0]              head_up;
    logic [PTR_W-1:0]              head_dn;
    logic [PTR_W-1:0]              tail_up;
    logic [PTR_W-1:0]              tail_dn;
    logic                          ram_we;
    logic                          ram_re;
    logic [PTR_W-1:0]              ram_waddr;
    logic [PTR_W-1:0]              ram_raddr;
    logic [dq_pkg::ENTRY_W-1:0]    ram_rdata;

    assign head_up = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign head_dn = (head_reg == '0) ? PTR_LAST : head_reg - PTR_W'(1);
    assign tail_up = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
    assign tail_dn = (tail_reg == '0) ? PTR_LAST : tail_reg - PTR_W'(1);

    assign is_push = (kind_reg == dq_pkg::KIND_PUSH_REAR)
                  || (kind_reg == dq_pkg::KIND_PUSH_FRONT);
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign push_ok = is_push && !full;
    assign pop_ok  = !is_push && !empty;

    assign stat.pop_ok = pop_ok;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ram_waddr   = tail_reg;
        ram_raddr   = head_reg;
        status_next = dq_pkg::STATUS_DONE;
        if (is_push && full)
        begin
            status_next = dq_pkg::STATUS_FULL;
        end
        else if (!is_push && empty)
        begin
            status_next = dq_pkg::STATUS_EMPTY;
        end
        else
        begin
            case (kind_reg)
                dq_pkg::KIND_PUSH_REAR:
                begin
                    ram_waddr  = tail_reg;
                    tail_next  = tail_up;
                    count_next = count_reg + CNT_W'(1);
                end
                dq_pkg::KIND_PUSH_FRONT:
                begin
                    ram_waddr  = head_dn;
                    head_next  = head_dn;
                    count_next = count_reg + CNT_W'(1);
                end
                dq_pkg::KIND_POP_FRONT:
                begin
                    ram_raddr  = head_reg;
                    head_next  = head_up;
                    count_next = count_reg - CNT_W'(1);
                end
                dq_pkg::KIND_POP_REAR:
                begin
                    ram_raddr  = tail_dn;
                    tail_next  = tail_dn;
                    count_next = count_reg - CNT_W'(1);
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign ram_we = cmd.exec && push_ok;
    assign ram_re = cmd.exec && pop_ok;

    dq_ram #(
        .WIDTH (dq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // operation and result holding registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= dq_pkg::kind_t'(kind);
            byte_reg <= push_byte;
        end
        if (cmd.exec)
        begin
            pop_byte_reg <= '0;
            status_reg   <= status_next;
            fill_reg     <= dq_pkg::FILL_W'(count_next);
        end
        else if (cmd.capture)
        begin
            pop_byte_reg <= ram_rdata;
        end
    end

    assign pop_byte   = pop_byte_reg;
    assign status     = status_reg;
    assign fill_count = fill_reg;

endmodule

`default_nettype wire

>>> hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Byte deque in a circular buffer: push or pop at either end, one result
// per operation with popped byte, status and fill count.
// ----------------------------------------------------------------------------
// sequence: an accepted operation runs through execute, then the done cycle
//   for pushes and rejected operations; a successful pop has a registered ram read between them
// one operation at a time: a new one is taken only once the last is done; busy is
//   high after acceptance through the done cycle
// done is a single-cycle strobe, the receiver cannot stall it
// reset: rst_n clears pointers and count; ram contents are not cleared
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [dq_pkg::KIND_W-1:0]     kind,
    input  wire logic [dq_pkg::ENTRY_W-1:0]    push_byte,
    output logic                               busy,
    output logic                               done,
    output logic      [dq_pkg::ENTRY_W-1:0]    pop_byte,
    output logic      [dq_pkg::STATUS_W-1:0]   status,
    output logic      [dq_pkg::FILL_W-1:0]     fill_count
);

    dq_pkg::dq_cmd_t  cmd;
    dq_pkg::dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (kind),
        .push_byte  (push_byte),
        .stat       (stat),
        .pop_byte   (pop_byte),
        .status     (status),
        .fill_count (fill_count)
    );

endmodule

`default_nettype wire
